>>> src/weo_pkg.sv
// Shared types and constants for the wheel encoder odometry core.
// Used by weo_delta, weo_div and wheel_encoder_odometry_core; no dependencies.

package weo_pkg;

	// default number of wheels with stored state
	localparam int WHEELS_DEF = 4;

	// field widths fixed by the stream format
	localparam int WHEEL_W = 2;
	localparam int COUNT_W = 16;
	localparam int ELAPSED_W = 16;
	localparam int DELTA_W = 17;
	localparam int TOTAL_W = 32;
	localparam int SPEED_W = 30;
	localparam int TICK_W = 16;
	localparam int MASK_W = 4;

	// register indexes on the config port
	localparam logic REG_REVERSE_MASK = 1'b0;
	localparam logic REG_TICK_LENGTH = 1'b1;

	// reset travel per tick: pi * 85 mm / 2264 ticks in Q0.16
	localparam logic [TICK_W-1:0] TICK_LEN_RESET = 16'd7730;

	// counter wrap correction
	localparam logic signed [17:0] WRAP_HALF = 18'sd15000;
	localparam logic signed [17:0] WRAP_SPAN = 18'sd60000;

	// speed scaling: mag * tick * 1000 / (elapsed * 256)
	localparam logic [9:0] MS_PER_S = 10'd1000;
	localparam int PROD_W = 32;
	localparam int NUM_W = 42;
	localparam int FRAC_DROP = 8;
	localparam int DIVIDEND_W = NUM_W - FRAC_DROP;
	localparam int DIVISOR_W = ELAPSED_W;
	localparam int DIV_CNT_W = $clog2(DIVIDEND_W + 1);

	// speed saturation limits
	localparam logic [SPEED_W-1:0] SPEED_MAX = 30'h1fff_ffff;
	localparam logic [SPEED_W-1:0] SPEED_MIN = 30'h2000_0000;

	// step strobes from the sequencer to the wheel state
	typedef struct packed {
		logic load;
		logic fix;
		logic sum;
	} step_ctl_t;

	// per-sample result of the wheel state
	typedef struct packed {
		logic hit;
		logic [DELTA_W-1:0] delta;
		logic [TOTAL_W-1:0] total;
	} step_res_t;

	// divider request and response
	typedef struct packed {
		logic start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DIVIDEND_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> src/weo_delta.sv
// Per-wheel last count and tick total, wrap-corrected delta.
// Depends on weo_pkg.

module weo_delta #(
	parameter int WHEELS = weo_pkg::WHEELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  weo_pkg::step_ctl_t            ctl,
	input  logic [weo_pkg::WHEEL_W-1:0]   wheel,
	input  logic [weo_pkg::COUNT_W-1:0]   count,
	input  logic [weo_pkg::MASK_W-1:0]    rev_mask,
	output weo_pkg::step_res_t            res
);

	logic [weo_pkg::COUNT_W-1:0] last_q [WHEELS];
	logic [weo_pkg::TOTAL_W-1:0] sum_q [WHEELS];

	logic [weo_pkg::WHEEL_W-1:0] wheel_q;
	logic hit_q;
	logic rev_q;
	logic signed [17:0] diff_q;
	logic [weo_pkg::DELTA_W-1:0] delta_q;
	logic [weo_pkg::TOTAL_W-1:0] total_q;

	logic [weo_pkg::COUNT_W-1:0] last_rd;
	logic [weo_pkg::TOTAL_W-1:0] sum_rd;
	logic hit_in;
	logic signed [17:0] corr;
	logic [weo_pkg::TOTAL_W-1:0] sum_new;

	// read the entry of the incoming wheel and the latched wheel
	always_comb begin
		last_rd = '0;
		sum_rd = '0;
		for (int i = 0; i < WHEELS; i++) begin
			if (32'(wheel) == i) last_rd = last_q[i];
			if (32'(wheel_q) == i) sum_rd = sum_q[i];
		end
	end

	assign hit_in = 32'(wheel) < 32'(WHEELS);

	// wrap correction and direction mapping
	always_comb begin
		if (diff_q > weo_pkg::WRAP_HALF) begin
			corr = diff_q - weo_pkg::WRAP_SPAN;
		end else if (diff_q < -weo_pkg::WRAP_HALF) begin
			corr = diff_q + weo_pkg::WRAP_SPAN;
		end else begin
			corr = diff_q;
		end
		if (rev_q) corr = -corr;
	end

	assign sum_new = sum_rd + {{(weo_pkg::TOTAL_W-weo_pkg::DELTA_W){delta_q[weo_pkg::DELTA_W-1]}},
		delta_q};

	// stored per-wheel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WHEELS; i++) begin
				last_q[i] <= '0;
				sum_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < WHEELS; i++) begin
				if (ctl.load && 32'(wheel) == i) last_q[i] <= count;
				if (ctl.sum && hit_q && 32'(wheel_q) == i) sum_q[i] <= sum_new;
			end
		end
	end

	// working registers of one sample
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			wheel_q <= wheel;
			hit_q <= hit_in;
			rev_q <= rev_mask[wheel];
			diff_q <= $signed({{2{count[weo_pkg::COUNT_W-1]}}, count})
				- $signed({{2{last_rd[weo_pkg::COUNT_W-1]}}, last_rd});
		end
		if (ctl.fix) delta_q <= hit_q ? corr[weo_pkg::DELTA_W-1:0] : '0;
		if (ctl.sum) total_q <= hit_q ? sum_new : '0;
	end

	assign res.hit = hit_q;
	assign res.delta = delta_q;
	assign res.total = total_q;

endmodule

>>> src/weo_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on weo_pkg.

module weo_div (
	input  logic              clk,
	input  logic              arst_n,
	input  weo_pkg::div_req_t req,
	output weo_pkg::div_rsp_t rsp
);

	logic busy_q;
	logic done_q;
	logic [weo_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [weo_pkg::DIVIDEND_W-1:0] quo_q;
	logic [weo_pkg::DIVISOR_W-1:0] rem_q;
	logic [weo_pkg::DIVISOR_W-1:0] dvs_q;

	logic [weo_pkg::DIVISOR_W:0] trial;
	logic no_borrow;

	// shift one dividend bit into the remainder and try to subtract
	always_comb begin
		trial = {rem_q, quo_q[weo_pkg::DIVIDEND_W-1]} - {1'b0, dvs_q};
		no_borrow = {rem_q, quo_q[weo_pkg::DIVIDEND_W-1]} >= {1'b0, dvs_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= weo_pkg::DIV_CNT_W'(weo_pkg::DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == weo_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quotient bits shift in behind the dividend
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[weo_pkg::DIVIDEND_W-2:0], no_borrow};
			rem_q <= no_borrow ? trial[weo_pkg::DIVISOR_W-1:0]
				: {rem_q[weo_pkg::DIVISOR_W-2:0], quo_q[weo_pkg::DIVIDEND_W-1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> src/wheel_encoder_odometry_core.sv
// Top level of the wheel encoder odometry core: sequencer, speed scaling, output register.
// Depends on weo_pkg, weo_delta and weo_div.
//
//  channel  dir  beat fields (tdata low bit up)                   tuser
//  s_*      in   count[15:0], elapsed[31:16]                       wheel
//  m_*      out  delta[16:0], tick_total[48:17], speed_q8[78:49]   wheel_out
//  cfg_*    in   cfg_idx 0 reverse_mask, 1 tick_length_q16         -
//
// A sample goes from its accepting edge to a valid result through four sequencer steps,
// the 34-step bit-serial divider, one step to take the quotient and one to load the
// output register. The sequencer accepts only when idle, so it takes no new sample until
// the previous one has left it, while that result may still wait in the output register.
// Reset clears all wheel state and returns both config registers to their defaults.
// A stalled output holds the sequencer in its last step until the register frees.

module wheel_encoder_odometry_core #(
	parameter int WHEELS = weo_pkg::WHEELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,  // count, elapsed
	input  logic [weo_pkg::WHEEL_W-1:0]   s_tuser,  // wheel
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [79:0]                   m_tdata,  // delta, tick_total, speed_q8, zero pad
	output logic [weo_pkg::WHEEL_W-1:0]   m_tuser,  // wheel_out
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [weo_pkg::TICK_W-1:0]    cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIX,
		ST_SUM,
		ST_MUL,
		ST_DGO,
		ST_DWAIT,
		ST_OUT
	} state_t;

	state_t state_q;

	logic [weo_pkg::MASK_W-1:0] rev_mask_q;
	logic [weo_pkg::TICK_W-1:0] tick_len_q;

	logic [weo_pkg::ELAPSED_W-1:0] elapsed_q;
	logic neg_q;
	logic [weo_pkg::PROD_W-1:0] prod_q;
	logic [weo_pkg::NUM_W-1:0] num_q;
	logic [weo_pkg::SPEED_W-1:0] speed_q;
	logic [weo_pkg::WHEEL_W-1:0] wheel_q;

	logic m_tvalid_q;
	logic [79:0] m_tdata_q;
	logic [weo_pkg::WHEEL_W-1:0] m_tuser_q;

	weo_pkg::step_ctl_t ctl;
	weo_pkg::step_res_t res;
	weo_pkg::div_req_t dreq;
	weo_pkg::div_rsp_t drsp;

	logic accept;
	logic out_free;
	logic [weo_pkg::DELTA_W-1:0] mag17;
	logic [weo_pkg::SPEED_W-1:0] speed_nx;
	logic [weo_pkg::DIVIDEND_W-1:0] q;

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// step strobes for the wheel state
	assign ctl.load = accept;
	assign ctl.fix = (state_q == ST_FIX);
	assign ctl.sum = (state_q == ST_SUM);

	weo_delta #(
		.WHEELS(WHEELS)
	) u_delta (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.wheel(s_tuser),
		.count(s_tdata[15:0]),
		.rev_mask(rev_mask_q),
		.res(res)
	);

	// divider sees mag * tick * 1000 with the Q8 scale folded in
	assign dreq.start = (state_q == ST_DGO);
	assign dreq.dividend = num_q[weo_pkg::NUM_W-1:weo_pkg::FRAC_DROP];
	assign dreq.divisor = elapsed_q;

	weo_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq),
		.rsp(drsp)
	);

	// magnitude of the delta, which stays below 2^16
	assign mag17 = res.delta[weo_pkg::DELTA_W-1] ? -res.delta : res.delta;

	// sign, saturation and zero cases of the speed
	always_comb begin
		q = drsp.quotient;
		if (!res.hit || elapsed_q == '0) begin
			speed_nx = '0;
		end else if (neg_q) begin
			if (q > weo_pkg::DIVIDEND_W'(weo_pkg::SPEED_MIN)) speed_nx = weo_pkg::SPEED_MIN;
			else speed_nx = -q[weo_pkg::SPEED_W-1:0];
		end else begin
			if (q > weo_pkg::DIVIDEND_W'(weo_pkg::SPEED_MAX)) speed_nx = weo_pkg::SPEED_MAX;
			else speed_nx = q[weo_pkg::SPEED_W-1:0];
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_mask_q <= '0;
			tick_len_q <= weo_pkg::TICK_LEN_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				weo_pkg::REG_REVERSE_MASK: rev_mask_q <= cfg_wdata[weo_pkg::MASK_W-1:0];
				weo_pkg::REG_TICK_LENGTH: tick_len_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			// result beat loads on the last step and clears once taken
			if (state_q == ST_OUT && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_FIX;
				ST_FIX: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_DGO;
				ST_DGO: state_q <= ST_DWAIT;
				ST_DWAIT: if (drsp.done) state_q <= ST_OUT;
				ST_OUT: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers of one sample
	always_ff @(posedge clk) begin
		if (accept) begin
			elapsed_q <= s_tdata[31:16];
			wheel_q <= s_tuser;
		end
		if (state_q == ST_SUM) begin
			neg_q <= res.delta[weo_pkg::DELTA_W-1];
			prod_q <= weo_pkg::PROD_W'(mag17[15:0]) * weo_pkg::PROD_W'(tick_len_q);
		end
		if (state_q == ST_MUL) begin
			num_q <= weo_pkg::NUM_W'(prod_q) * weo_pkg::NUM_W'(weo_pkg::MS_PER_S);
		end
		if (state_q == ST_DWAIT && drsp.done) speed_q <= speed_nx;
		if (state_q == ST_OUT && out_free) begin
			m_tdata_q <= {1'b0, speed_q, res.total, res.delta};
			m_tuser_q <= wheel_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

endmodule
